### rtl/core/dbpq_pkg.sv
// Shared types and constants for the degree bucket priority queue.
`timescale 1ns / 1ps
package dbpq_pkg;
	localparam int NODE_W = 10;
	localparam int LINK_W = 11;
	localparam int KEY_W = 20;
	localparam int BKT_W = 12;
	localparam int CNT_W = 11;
	localparam int MAX_NODES = 1024;
	localparam int NBUCKETS = 2 * MAX_NODES + 1;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_NODES);
	localparam logic [KEY_W-1:0] MAX_KEY = 20'hFFFFF;
	localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NBUCKETS - 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_POP    = 2'd1,
		OP_INC    = 2'd2,
		OP_DEC    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_ABSENT   = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		UOP_NOP,
		UOP_CLR,
		UOP_LATCH,
		UOP_READV,
		UOP_FIN_EMPTY,
		UOP_FIN_ABSENT,
		UOP_FIN_OVF,
		UOP_DIV_DEG,
		UOP_DIV_KEY,
		UOP_DIV_NK,
		UOP_STORE_NB,
		UOP_UNLINK,
		UOP_KEY_W,
		UOP_PUSH_RD,
		UOP_PUSH_W1,
		UOP_PUSH_W2,
		UOP_SCAN_INIT,
		UOP_SCAN_NEXT,
		UOP_SCAN_HIT,
		UOP_POP_W
	} uop_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_CHKV,
		S_DIVO,
		S_DIVN,
		S_CHKN,
		S_PUSH_RD,
		S_PUSH_W1,
		S_PUSH_W2,
		S_SCAN_CHK,
		S_POP_W,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		uop_t uop;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic v_bad;
		logic present;
		logic key_max;
		logic key_zero;
		logic key_one;
		logic cnt_zero;
		logic div_done;
		logic nb_ovf;
		logic same_bkt;
		logic head_hit;
		logic scan_last;
		logic clr_last;
	} dp_stat_t;
endpackage

### rtl/core/degree_bucket_priority_queue.sv
// Top level: minimum-degree bucket priority queue with APB configuration.
// Operations: a bad node, an empty queue, an absent node, or a key or bucket overflow ends
//   early; insert divides the degree, increment or decrement the old and the new key; the
//   node then goes to the head of its new bucket unless it stays in the old one; pop scans.
// Throughput: one operation at a time; each returns to idle before the next is taken.
// Reset and each node_count write made while idle run a clearing pass with busy high; the
//   receiver cannot stall, and each result strobes on done for one cycle.
`timescale 1ns / 1ps
module degree_bucket_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [9:0]  node,
	input  logic [19:0] degree,
	output logic        done,
	output logic [9:0]  popped_node,
	output logic [1:0]  status,
	output logic [10:0] items_left
);
	import dbpq_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             cfg_we;
	logic [CNT_W-1:0] node_count;

	// register transfer to node_count
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = paddr[2] ? 32'd0 : {21'd0, node_count};

	dbpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dbpq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (pwdata[CNT_W-1:0]),
		.node_count  (node_count),
		.operation   (operation),
		.node        (node),
		.degree      (degree),
		.popped_node (popped_node),
		.status      (status),
		.items_left  (items_left)
	);
endmodule

### rtl/core/dbpq_div.sv
// Restoring divider, one quotient bit per cycle, for the bucket mapping.
`timescale 1ns / 1ps
module dbpq_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dbpq_pkg::KEY_W-1:0] dividend,
	input  logic [dbpq_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [dbpq_pkg::KEY_W-1:0] quotient
);
	import dbpq_pkg::*;

	logic [CNT_W-1:0] rem_q;
	logic [KEY_W-1:0] quo_q;
	logic [CNT_W-1:0] dvs_q;
	logic [4:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[KEY_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(KEY_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[KEY_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

### rtl/core/dbpq_datapath.sv
// Datapath: list memories, bucket mapping, counters and result registers.
`timescale 1ns / 1ps
module dbpq_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dbpq_pkg::dp_cmd_t           cmd,
	output dbpq_pkg::dp_stat_t          stat,
	input  logic                        cfg_we,
	input  logic [dbpq_pkg::CNT_W-1:0]  cfg_wdata,
	output logic [dbpq_pkg::CNT_W-1:0]  node_count,
	input  logic [1:0]                  operation,
	input  logic [dbpq_pkg::NODE_W-1:0] node,
	input  logic [dbpq_pkg::KEY_W-1:0]  degree,
	output logic [dbpq_pkg::NODE_W-1:0] popped_node,
	output logic [1:0]                  status,
	output logic [dbpq_pkg::CNT_W-1:0]  items_left
);
	import dbpq_pkg::*;

	// memories
	logic [LINK_W-1:0] head_mem [NBUCKETS];
	logic [LINK_W-1:0] next_mem [MAX_NODES];
	logic [LINK_W-1:0] prev_mem [MAX_NODES];
	logic [KEY_W-1:0]  key_mem [MAX_NODES];
	logic              pres_mem [MAX_NODES];

	logic [LINK_W-1:0] head_rd_q, next_rd_q, prev_rd_q;
	logic [KEY_W-1:0]  key_rd_q;
	logic              pres_rd_q;

	logic [BKT_W-1:0]  head_ra, head_wa;
	logic [LINK_W-1:0] head_wd;
	logic              head_we;
	logic [NODE_W-1:0] next_ra, next_wa, prev_wa;
	logic [LINK_W-1:0] next_wd, prev_wd;
	logic              next_we, prev_we;
	logic [KEY_W-1:0]  key_wd;
	logic              key_we;
	logic [NODE_W-1:0] pres_wa;
	logic              pres_wd, pres_we;

	// registers
	logic [CNT_W-1:0]  ncount_q;
	op_t               op_q;
	logic [NODE_W-1:0] v_q;
	logic [KEY_W-1:0]  deg_q, nk_q, dvd_q;
	logic [LINK_W-1:0] p_q, q_q, h_q;
	logic [BKT_W-1:0]  ob_q, nb_q, min_q, scan_q, clr_q;
	logic              nb_ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	status_t           status_q;
	logic [NODE_W-1:0] popped_q;

	logic [CNT_W-1:0]  neff;
	logic              div_start, div_done;
	logic [KEY_W-1:0]  div_dvd, quo;
	logic [KEY_W:0]    bsum;
	logic              low_key;
	logic [BKT_W-1:0]  bkt;
	logic              bovf;
	logic [KEY_W-1:0]  key_step;

	// effective node count: zero acts as one, clamp at capacity
	always_comb begin
		if (ncount_q == '0)
			neff = CNT_W'(1);
		else if (ncount_q > CNT_W'(MAX_NODES))
			neff = CNT_W'(MAX_NODES);
		else
			neff = ncount_q;
	end

	// bucket of the last divided key
	always_comb begin
		bsum    = {10'd0, neff} + {1'b0, quo};
		low_key = dvd_q <= {9'd0, neff};
		bkt     = low_key ? dvd_q[BKT_W-1:0] : bsum[BKT_W-1:0];
		bovf    = !low_key && (bsum > (KEY_W+1)'(NBUCKETS - 1));
	end

	assign key_step = (op_q == OP_INC) ? key_rd_q + 20'd1 : key_rd_q - 20'd1;

	// divider launch
	always_comb begin
		div_start = 1'b0;
		div_dvd   = deg_q;
		case (cmd.uop)
			UOP_DIV_DEG: begin
				div_start = 1'b1;
				div_dvd   = deg_q;
			end
			UOP_DIV_KEY: begin
				div_start = 1'b1;
				div_dvd   = key_rd_q;
			end
			UOP_DIV_NK: begin
				div_start = 1'b1;
				div_dvd   = nk_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dbpq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (neff),
		.done     (div_done),
		.quotient (quo)
	);

	// memory port steering
	always_comb begin
		head_ra = nb_q;
		next_ra = v_q;
		head_we = 1'b0; head_wa = nb_q;  head_wd = NIL;
		next_we = 1'b0; next_wa = v_q;   next_wd = NIL;
		prev_we = 1'b0; prev_wa = v_q;   prev_wd = NIL;
		key_we  = 1'b0; key_wd  = nk_q;
		pres_we = 1'b0; pres_wa = v_q;   pres_wd = 1'b0;
		case (cmd.uop)
			UOP_CLR: begin
				head_we = 1'b1;
				head_wa = clr_q;
				head_wd = NIL;
				pres_we = (clr_q < BKT_W'(MAX_NODES));
				pres_wa = clr_q[NODE_W-1:0];
				pres_wd = 1'b0;
			end
			UOP_UNLINK: begin
				prev_we = !q_q[LINK_W-1];
				prev_wa = q_q[NODE_W-1:0];
				prev_wd = p_q;
				next_we = !p_q[LINK_W-1];
				next_wa = p_q[NODE_W-1:0];
				next_wd = q_q;
				head_we = p_q[LINK_W-1];
				head_wa = ob_q;
				head_wd = q_q;
			end
			UOP_KEY_W: begin
				key_we = 1'b1;
			end
			UOP_PUSH_RD: begin
				head_ra = nb_q;
			end
			UOP_PUSH_W1: begin
				prev_we = 1'b1;
				prev_wa = v_q;
				prev_wd = NIL;
				next_we = 1'b1;
				next_wa = v_q;
				next_wd = head_rd_q;
				head_we = 1'b1;
				head_wa = nb_q;
				head_wd = {1'b0, v_q};
				key_we  = 1'b1;
				pres_we = 1'b1;
				pres_wa = v_q;
				pres_wd = 1'b1;
			end
			UOP_PUSH_W2: begin
				prev_we = !h_q[LINK_W-1];
				prev_wa = h_q[NODE_W-1:0];
				prev_wd = {1'b0, v_q};
			end
			UOP_SCAN_INIT: begin
				head_ra = min_q;
			end
			UOP_SCAN_NEXT: begin
				head_ra = scan_q + 12'd1;
			end
			UOP_SCAN_HIT: begin
				next_ra = head_rd_q[NODE_W-1:0];
			end
			UOP_POP_W: begin
				head_we = 1'b1;
				head_wa = scan_q;
				head_wd = next_rd_q;
				prev_we = !next_rd_q[LINK_W-1];
				prev_wa = next_rd_q[NODE_W-1:0];
				prev_wd = NIL;
				pres_we = 1'b1;
				pres_wa = h_q[NODE_W-1:0];
				pres_wd = 1'b0;
			end
			default: begin
				head_we = 1'b0;
			end
		endcase
	end

	// bucket heads
	always_ff @(posedge clk) begin
		if (head_we)
			head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[head_ra];
	end

	// forward links
	always_ff @(posedge clk) begin
		if (next_we)
			next_mem[next_wa] <= next_wd;
		next_rd_q <= next_mem[next_ra];
	end

	// backward links
	always_ff @(posedge clk) begin
		if (prev_we)
			prev_mem[prev_wa] <= prev_wd;
		prev_rd_q <= prev_mem[v_q];
	end

	// node keys
	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[v_q] <= key_wd;
		key_rd_q <= key_mem[v_q];
	end

	// presence flags
	always_ff @(posedge clk) begin
		if (pres_we)
			pres_mem[pres_wa] <= pres_wd;
		pres_rd_q <= pres_mem[v_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= CNT_W'(MAX_NODES);
			clr_q    <= '0;
			cnt_q    <= '0;
			min_q    <= '0;
			status_q <= STAT_OK;
			popped_q <= '0;
		end else begin
			if (cfg_we)
				ncount_q <= cfg_wdata;
			case (cmd.uop)
				UOP_CLR: begin
					clr_q <= (clr_q == LAST_BKT) ? '0 : clr_q + 12'd1;
					cnt_q <= '0;
					min_q <= '0;
				end
				UOP_LATCH: begin
					status_q <= STAT_OK;
					popped_q <= '0;
				end
				UOP_FIN_EMPTY:  status_q <= STAT_EMPTY;
				UOP_FIN_ABSENT: status_q <= STAT_ABSENT;
				UOP_FIN_OVF:    status_q <= STAT_OVERFLOW;
				UOP_PUSH_W1: begin
					if (op_q == OP_INSERT)
						cnt_q <= cnt_q + 11'd1;
					if (op_q != OP_INC && nb_q < min_q)
						min_q <= nb_q;
				end
				UOP_POP_W: begin
					cnt_q    <= cnt_q - 11'd1;
					min_q    <= scan_q;
					popped_q <= h_q[NODE_W-1:0];
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// operand registers
	always_ff @(posedge clk) begin
		case (cmd.uop)
			UOP_LATCH: begin
				op_q  <= op_t'(operation);
				v_q   <= node;
				deg_q <= degree;
			end
			UOP_DIV_DEG: begin
				nk_q  <= deg_q;
				dvd_q <= deg_q;
			end
			UOP_DIV_KEY: begin
				nk_q  <= key_step;
				dvd_q <= key_rd_q;
				p_q   <= prev_rd_q;
				q_q   <= next_rd_q;
			end
			UOP_DIV_NK: begin
				ob_q  <= bkt;
				dvd_q <= nk_q;
			end
			UOP_STORE_NB: begin
				nb_q     <= bkt;
				nb_ovf_q <= bovf;
			end
			UOP_PUSH_W1:   h_q    <= head_rd_q;
			UOP_SCAN_INIT: scan_q <= min_q;
			UOP_SCAN_NEXT: scan_q <= scan_q + 12'd1;
			UOP_SCAN_HIT:  h_q    <= head_rd_q;
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	// status to the controller
	always_comb begin
		stat.op        = op_q;
		stat.v_bad     = {1'b0, v_q} >= neff;
		stat.present   = pres_rd_q;
		stat.key_max   = key_rd_q >= MAX_KEY;
		stat.key_zero  = key_rd_q == '0;
		stat.key_one   = key_rd_q == 20'd1;
		stat.cnt_zero  = cnt_q == '0;
		stat.div_done  = div_done;
		stat.nb_ovf    = nb_ovf_q;
		stat.same_bkt  = ob_q == nb_q;
		stat.head_hit  = !head_rd_q[LINK_W-1];
		stat.scan_last = scan_q == LAST_BKT;
		stat.clr_last  = clr_q == LAST_BKT;
	end

	assign node_count  = ncount_q;
	assign popped_node = popped_q;
	assign status      = status_q;
	assign items_left  = cnt_q;

	// the queue never holds more nodes than it has entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_NODES))
		else $error("item count above capacity");

	// the minimum pointer stays inside the bucket array
	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= LAST_BKT)
		else $error("minimum bucket out of range");

	// a pop removes exactly one node
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.uop == UOP_POP_W |=> cnt_q == $past(cnt_q) - 11'd1)
		else $error("pop did not decrement item count");
endmodule

### rtl/core/dbpq_ctrl.sv
// Controller: sequences each operation as a series of datapath commands.
`timescale 1ns / 1ps
module dbpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_we,
	input  dbpq_pkg::dp_stat_t stat,
	output dbpq_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import dbpq_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register; reset begins with the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.uop = UOP_NOP;
		case (state_q)
			S_CLEAR: begin
				cmd.uop = UOP_CLR;
				if (stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_we) begin
					state_d = S_CLEAR;
				end else if (start) begin
					cmd.uop = UOP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.op == OP_POP) begin
					if (stat.cnt_zero) begin
						cmd.uop = UOP_FIN_EMPTY;
						state_d = S_DONE;
					end else begin
						cmd.uop = UOP_SCAN_INIT;
						state_d = S_SCAN_CHK;
					end
				end else if (stat.v_bad) begin
					cmd.uop = UOP_FIN_ABSENT;
					state_d = S_DONE;
				end else begin
					cmd.uop = UOP_READV;
					state_d = S_CHKV;
				end
			end
			S_CHKV: begin
				if (stat.op == OP_INSERT) begin
					if (stat.present) begin
						cmd.uop = UOP_FIN_ABSENT;
						state_d = S_DONE;
					end else begin
						cmd.uop = UOP_DIV_DEG;
						state_d = S_DIVN;
					end
				end else if (!stat.present) begin
					cmd.uop = UOP_FIN_ABSENT;
					state_d = S_DONE;
				end else if (stat.op == OP_INC && stat.key_max) begin
					cmd.uop = UOP_FIN_OVF;
					state_d = S_DONE;
				end else if (stat.op == OP_DEC && stat.key_zero) begin
					cmd.uop = UOP_FIN_OVF;
					state_d = S_DONE;
				end else if (stat.op == OP_DEC && stat.key_one) begin
					state_d = S_DONE;
				end else begin
					cmd.uop = UOP_DIV_KEY;
					state_d = S_DIVO;
				end
			end
			S_DIVO: begin
				if (stat.div_done) begin
					cmd.uop = UOP_DIV_NK;
					state_d = S_DIVN;
				end
			end
			S_DIVN: begin
				if (stat.div_done) begin
					cmd.uop = UOP_STORE_NB;
					state_d = S_CHKN;
				end
			end
			S_CHKN: begin
				if (stat.nb_ovf) begin
					cmd.uop = UOP_FIN_OVF;
					state_d = S_DONE;
				end else if (stat.op == OP_INSERT) begin
					state_d = S_PUSH_RD;
				end else if (stat.same_bkt) begin
					cmd.uop = UOP_KEY_W;
					state_d = S_DONE;
				end else begin
					cmd.uop = UOP_UNLINK;
					state_d = S_PUSH_RD;
				end
			end
			S_PUSH_RD: begin
				cmd.uop = UOP_PUSH_RD;
				state_d = S_PUSH_W1;
			end
			S_PUSH_W1: begin
				cmd.uop = UOP_PUSH_W1;
				state_d = S_PUSH_W2;
			end
			S_PUSH_W2: begin
				cmd.uop = UOP_PUSH_W2;
				state_d = S_DONE;
			end
			S_SCAN_CHK: begin
				if (stat.head_hit) begin
					cmd.uop = UOP_SCAN_HIT;
					state_d = S_POP_W;
				end else if (stat.scan_last) begin
					cmd.uop = UOP_FIN_EMPTY;
					state_d = S_DONE;
				end else begin
					cmd.uop = UOP_SCAN_NEXT;
				end
			end
			S_POP_W: begin
				cmd.uop = UOP_POP_W;
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	// a result strobe lasts one cycle and is followed by an idle block
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe not a single cycle");
endmodule
